// File: src/lebd_pkg.sv
// Package for the LEB128 stream decoder: payload structs, status codes,
// decoder state type and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lebd_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned GROUP_W  = 7;

    localparam logic [BYTE_W-1:0]  FIFTH_MAX   = 8'h0f;
    localparam logic [COUNT_W-1:0] LAST_GROUPS = 3'd4;
    localparam logic [COUNT_W-1:0] MAX_BYTES   = 3'd5;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_FIFTH_BIG = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } t_lebd_status;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              func;
        logic              end_of_data;
    } t_lebd_in;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        t_lebd_status       status;
        logic [COUNT_W-1:0] byte_count;
    } t_lebd_out;

    typedef struct packed {
        logic [DATA_W-1:0]  accumulator;
        logic [COUNT_W-1:0] bytes_seen;
        logic               signed_latched;
    } t_lebd_state;

endpackage

`default_nettype wire

// File: src/lebd_step.sv
// Combinational decode step: merges one stream byte into the decoder
// state and forms the result when a value ends. Depends on lebd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lebd_step (
    input  lebd_pkg::t_lebd_state i_state,
    input  lebd_pkg::t_lebd_in    i_in,
    output lebd_pkg::t_lebd_state o_next,
    output lebd_pkg::t_lebd_out   o_result,
    output logic                  o_res_valid
);
    import lebd_pkg::*;

    logic [COUNT_W-1:0] n;
    logic               sgn;
    logic [DATA_W-1:0]  acc_new;
    logic [DATA_W-1:0]  group;
    logic [DATA_W-1:0]  val;
    t_lebd_status       status;
    logic [COUNT_W-1:0] count;
    logic               done;

    assign n     = i_state.bytes_seen;
    assign sgn   = (n == '0) ? i_in.func : i_state.signed_latched;
    assign group = {{(DATA_W-GROUP_W){1'b0}}, i_in.data_byte[GROUP_W-1:0]};

    always_comb begin
        acc_new = i_state.accumulator;
        val     = '0;
        status  = STATUS_OK;
        count   = MAX_BYTES;
        done    = 1'b1;
        if (n < LAST_GROUPS) begin
            case (n)
                3'd0:    acc_new = i_state.accumulator | group;
                3'd1:    acc_new = i_state.accumulator | (group << 7);
                3'd2:    acc_new = i_state.accumulator | (group << 14);
                default: acc_new = i_state.accumulator | (group << 21);
            endcase
            count = n + 3'd1;
            if (i_in.data_byte[BYTE_W-1]) begin
                if (!i_in.end_of_data) begin
                    done = 1'b0;
                end else begin
                    status = STATUS_TRUNCATED;
                end
            end else if (sgn) begin
                // Sign-extend from the top bit of the last 7-bit group.
                case (n)
                    3'd0:    val = {{25{acc_new[6]}}, acc_new[6:0]};
                    3'd1:    val = {{18{acc_new[13]}}, acc_new[13:0]};
                    3'd2:    val = {{11{acc_new[20]}}, acc_new[20:0]};
                    default: val = {{4{acc_new[27]}}, acc_new[27:0]};
                endcase
            end else begin
                val = acc_new;
            end
        end else begin
            acc_new = i_state.accumulator | {i_in.data_byte[3:0], 28'd0};
            if (i_in.data_byte > FIFTH_MAX) begin
                status = STATUS_FIFTH_BIG;
            end else if (!sgn && acc_new[DATA_W-1]) begin
                status = STATUS_OVERFLOW;
            end else begin
                val = acc_new;
            end
        end
    end

    always_comb begin
        o_next.signed_latched = sgn;
        if (done) begin
            o_next.accumulator = '0;
            o_next.bytes_seen  = '0;
        end else begin
            o_next.accumulator = acc_new;
            o_next.bytes_seen  = n + 3'd1;
        end
        o_result.value      = (status == STATUS_OK) ? val : '0;
        o_result.status     = status;
        o_result.byte_count = count;
        o_res_valid         = done;
    end

endmodule

`default_nettype wire

// File: src/leb128_stream_decoder_unit.sv
// Top level of the LEB128 stream decoder: input register, decode step and
// result register with valid/ready channels. Depends on lebd_pkg, lebd_step.
`timescale 1ns / 1ps
`default_nettype none

// Decodes 32-bit LEB128 values from a byte stream, one byte per
// transaction. The first byte of a value selects unsigned or signed
// decoding. One result transaction is produced when a value ends or an
// error is found; bytes in mid-value produce none. The block takes one
// byte every clock cycle as long as the result side keeps up; a byte
// passes through the input register and then the result register before
// its result appears. A pending result that is not taken holds the next
// result-producing byte in the input register, and new bytes wait behind
// it; bytes in mid-value still pass while a result waits.
module leb128_stream_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lebd_pkg::t_lebd_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lebd_pkg::t_lebd_out o_out_data
);
    import lebd_pkg::*;

    logic        r_in_valid;
    t_lebd_in    r_in_data;
    t_lebd_state r_state;
    logic        r_out_valid;
    t_lebd_out   r_out_data;

    t_lebd_state n_state;
    t_lebd_out   n_out_data;
    logic        step_res_valid;
    logic        out_free;
    logic        advance;

    lebd_step u_step (
        .i_state     (r_state),
        .i_in        (r_in_data),
        .o_next      (n_state),
        .o_result    (n_out_data),
        .o_res_valid (step_res_valid)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!step_res_valid || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= advance && step_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
        if (out_free && advance && step_res_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: src/lebd_checker.sv
// Port-level checks for the LEB128 stream decoder and the bind that attaches
// them to the top level. Depends on lebd_pkg, leb128_stream_decoder_unit.
`timescale 1ns / 1ps
`default_nettype none

module lebd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lebd_pkg::t_lebd_out o_out_data
);
    import lebd_pkg::*;

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // An error result carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != STATUS_OK |-> o_out_data.value == '0)
        else $error("error result with nonzero value");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.byte_count >= 3'd1 && o_out_data.byte_count <= MAX_BYTES)
        else $error("byte count out of range");

    // Fifth-byte and overflow errors are only found on a fifth byte.
    a_fifth_errs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STATUS_FIFTH_BIG ||
                        o_out_data.status == STATUS_OVERFLOW)
        |-> o_out_data.byte_count == MAX_BYTES)
        else $error("fifth-byte error with wrong byte count");

    a_trunc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_TRUNCATED
        |-> o_out_data.byte_count <= LAST_GROUPS)
        else $error("truncation reported on a fifth byte");

endmodule

bind leb128_stream_decoder_unit lebd_checker u_lebd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
